[hdl/cfir_pkg.sv]
// Shared types, widths and helpers for the causal FIR filter.
// No dependencies; imported by every module of the filter.
package cfir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COEFF_W      = 16;
    localparam int MAX_TAPS     = 8;
    localparam int TAPS_DEFAULT = 8;
    localparam int FRAC_BITS    = 14;
    localparam int PROD_W       = SAMPLE_W + COEFF_W;
    localparam int SUM_W        = PROD_W + $clog2(MAX_TAPS);
    localparam int CFG_IDX_W    = $clog2(MAX_TAPS);
    localparam int TDATA_W      = ((SAMPLE_W + 7) / 8) * 8;

    localparam logic signed [COEFF_W-1:0] COEFF_UNITY = COEFF_W'(1 << FRAC_BITS);
    localparam logic signed [COEFF_W-1:0] COEFF_ZERO  = '0;

    // One configuration write as seen by every cell
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [COEFF_W-1:0]   data;
    } cfg_wr_t;

    // Shift control for the tap delay line
    typedef struct packed {
        logic load;   // a beat is accepted: shift and form products
        logic clear;  // the beat ends a signal: zero the history
    } shift_ctl_t;

    // Add one half LSB, floor-shift by FRAC_BITS, saturate to a sample
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] sum
    );
        logic [SUM_W:0]            rnd;
        logic [SUM_W-FRAC_BITS:0]  q;
        logic                      fits;
        rnd  = {sum[SUM_W-1], sum} + (SUM_W+1)'(1 << (FRAC_BITS - 1));
        q    = rnd[SUM_W:FRAC_BITS];
        fits = (&q[SUM_W-FRAC_BITS:SAMPLE_W-1]) | ~(|q[SUM_W-FRAC_BITS:SAMPLE_W-1]);
        if (fits) begin
            return q[SAMPLE_W-1:0];
        end else if (q[SUM_W-FRAC_BITS]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

[hdl/cfir_cell.sv]
// One tap of the FIR delay line: coefficient, history sample and product register.
// Depends on cfir_pkg.
module cfir_cell
    import cfir_pkg::*;
#(
    parameter int                         IDX         = 0,
    parameter logic signed [COEFF_W-1:0]  COEFF_RESET = COEFF_ZERO
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfg_wr_t                     cfg,
    input  shift_ctl_t                  ctl,
    input  logic signed [SAMPLE_W-1:0]  tap_in,
    output logic signed [SAMPLE_W-1:0]  tap_out,
    output logic signed [PROD_W-1:0]    prod_out
);

    logic signed [COEFF_W-1:0]  coeff_reg;
    logic signed [SAMPLE_W-1:0] hist_reg;
    logic signed [SAMPLE_W-1:0] hist_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;

    // drop the history at the end of a signal, else pass the sample on
    assign hist_next = ctl.clear ? '0 : tap_in;
    assign prod_next = PROD_W'(tap_in * coeff_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= COEFF_RESET;
            hist_reg  <= '0;
        end else begin
            if (cfg.we && cfg.index == CFG_IDX_W'(IDX)) begin
                coeff_reg <= cfg.data;
            end
            if (ctl.load) begin
                hist_reg <= hist_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            prod_reg <= prod_next;
        end
    end

    assign tap_out  = hist_reg;
    assign prod_out = prod_reg;

endmodule

[hdl/cfir_sum.sv]
// Registered adder tree with rounding/saturation and the output register.
// Depends on cfir_pkg.
module cfir_sum
    import cfir_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic signed [PROD_W-1:0]    prod [MAX_TAPS],
    input  logic                        in_valid,
    input  logic                        in_last,
    output logic                        in_ready,
    output logic signed [SAMPLE_W-1:0]  out_data,
    output logic                        out_last,
    output logic                        out_valid,
    input  logic                        out_ready
);

    localparam int A_N = MAX_TAPS / 2;
    localparam int B_N = MAX_TAPS / 4;

    logic signed [PROD_W:0]   a_reg [A_N];
    logic signed [PROD_W+1:0] b_reg [B_N];
    logic signed [SUM_W-1:0]  c_reg;
    logic signed [SAMPLE_W-1:0] d_reg;
    logic [3:0] vld_reg, vld_next;
    logic [3:0] lst_reg;
    logic [3:0] rdy;

    // a stage takes a beat when it is empty or its successor moves
    assign rdy[3] = !vld_reg[3] || out_ready;
    assign rdy[2] = !vld_reg[2] || rdy[3];
    assign rdy[1] = !vld_reg[1] || rdy[2];
    assign rdy[0] = !vld_reg[0] || rdy[1];

    always_comb begin
        vld_next[0] = rdy[0] ? in_valid   : vld_reg[0];
        vld_next[1] = rdy[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = rdy[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = rdy[3] ? vld_reg[2] : vld_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            for (int i = 0; i < A_N; i++) begin
                a_reg[i] <= (PROD_W+1)'(prod[2*i]) + (PROD_W+1)'(prod[2*i+1]);
            end
            lst_reg[0] <= in_last;
        end
        if (rdy[1] && vld_reg[0]) begin
            for (int i = 0; i < B_N; i++) begin
                b_reg[i] <= (PROD_W+2)'(a_reg[2*i]) + (PROD_W+2)'(a_reg[2*i+1]);
            end
            lst_reg[1] <= lst_reg[0];
        end
        if (rdy[2] && vld_reg[1]) begin
            c_reg      <= SUM_W'(b_reg[0]) + SUM_W'(b_reg[1]);
            lst_reg[2] <= lst_reg[1];
        end
        if (rdy[3] && vld_reg[2]) begin
            d_reg      <= round_sat(c_reg);
            lst_reg[3] <= lst_reg[2];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[3];
    assign out_data  = d_reg;
    assign out_last  = lst_reg[3];

endmodule

[hdl/causal_fir_filter.sv]
// Causal direct-form FIR filter, up to eight taps, built as a row of tap cells.
// An accepted input beat passes the product register, three adder-tree levels and the output register to m_axis.
// Throughput: one sample per clock while m_axis_tready holds; each cell multiplies once per beat.
// Reset (aresetn low, synchronous): history zeroed, coeff_0 = 1.0, others 0.
// Depends on cfir_pkg, cfir_cell and cfir_sum.
module causal_fir_filter
    import cfir_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // coefficient write port, index i writes coeff_i
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]   cfg_wdata,
    // input samples
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [15:0] sample_in
    input  logic                 s_axis_tlast,   // end_of_signal
    // filtered samples
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [15:0] filtered
    output logic                 m_axis_tlast    // end_out
);

    // Sample chain: entry 0 is the incoming sample, entry j the sample
    // j beats back. Cell j weights entry j and hands it to cell j+1.
    logic signed [SAMPLE_W-1:0] samp [TAPS+1];
    logic signed [PROD_W-1:0]   prod [MAX_TAPS];

    cfg_wr_t    cfg;
    shift_ctl_t ctl;

    logic accept;
    logic p_valid_reg, p_valid_next;
    logic p_last_reg;
    logic sum_ready;

    // Product stage can take a new beat when empty or draining into the tree;
    // bubbles in the tree let the input keep flowing while the output waits.
    assign s_axis_tready = !p_valid_reg || sum_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    // Shift the delay line on every accepted beat; zero it after end of signal
    assign ctl.load  = accept;
    assign ctl.clear = s_axis_tlast;

    assign samp[0] = s_axis_tdata[SAMPLE_W-1:0];

    // Each cell hands its history sample to the next cell of the row
    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_tap
        if (j < TAPS) begin : g_cell
            cfir_cell #(
                .IDX         (j),
                .COEFF_RESET ((j == 0) ? COEFF_UNITY : COEFF_ZERO)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cfg      (cfg),
                .ctl      (ctl),
                .tap_in   (samp[j]),
                .tap_out  (samp[j+1]),
                .prod_out (prod[j])
            );
        end else begin : g_none
            // Taps beyond TAPS add nothing
            assign prod[j] = '0;
        end
    end

    // Valid and last travel beside the product registers in the cells
    assign p_valid_next = accept ? 1'b1 : (sum_ready ? 1'b0 : p_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_last_reg <= s_axis_tlast;
        end
    end

    logic signed [SAMPLE_W-1:0] filt;

    // Sum the products over three tree levels, round, saturate and hold
    // the result in the output register until it is taken.
    cfir_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .prod      (prod),
        .in_valid  (p_valid_reg),
        .in_last   (p_last_reg),
        .in_ready  (sum_ready),
        .out_data  (filt),
        .out_last  (m_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = TDATA_W'($unsigned(filt));

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // Reset empties the whole pipeline; checked here on the output valid
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A product beat that cannot move on stays put with its marker
    a_prod_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && !sum_ready |=> p_valid_reg && $stable(p_last_reg))
        else $error("product stage lost a stalled beat");

    if (TAPS > 1) begin : g_hist_chk
        // End of signal zeroes the newest history sample
        a_hist_clear: assert property (@(posedge aclk) disable iff (!aresetn)
            accept && s_axis_tlast |=> samp[1] == '0)
            else $error("history not cleared after end of signal");

        // Otherwise the accepted sample becomes the newest history entry
        a_hist_shift: assert property (@(posedge aclk) disable iff (!aresetn)
            accept && !s_axis_tlast |=> samp[1] == $past(samp[0]))
            else $error("history did not shift in the accepted sample");
    end

endmodule
